// ===== src/i2c_master_register_transactions_assert.svh =====
// Assertion macros shared by the I2C master register transaction block.
`ifndef I2C_MASTER_REGISTER_TRANSACTIONS_ASSERT_SVH
`define I2C_MASTER_REGISTER_TRANSACTIONS_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define I2CM_ASSERT_HOLDS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
	else $error("assertion failed");
`define I2CM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`else
`define I2CM_ASSERT_HOLDS(label, clk, rst_n, expr)
`define I2CM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/i2cm_pkg.sv =====
// Types and constants of the I2C master register transaction block.
package i2cm_pkg;
	localparam int QDepth = 2;
	localparam logic [7:0] RecoverPulses = 8'd9;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		K_TICK, K_WRITE, K_READ, K_PARAM
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_PARAM  = 3'd1,
		ST_BUSY   = 3'd2,
		ST_DEVW   = 3'd3,
		ST_REG    = 3'd4,
		ST_DATA   = 3'd5,
		ST_DEVR   = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		STG_DEVW = 3'd0,
		STG_REG  = 3'd1,
		STG_VAL  = 3'd2,
		STG_DEVR = 3'd3,
		STG_READ = 3'd4
	} stage_t;

	typedef enum logic [4:0] {
		PH_IDLE, PH_R_REL, PH_R_LOW, PH_R_HIGH, PH_R_STA, PH_R_STB, PH_R_STC,
		PH_S_A, PH_S_B, PH_S_C, PH_W_DATA, PH_W_HIGH, PH_W_LOW, PH_W_AREL,
		PH_W_AHIGH, PH_W_ALOW, PH_D_HIGH, PH_D_LOW, PH_D_ASET, PH_D_AHIGH,
		PH_D_ALOW, PH_P_A, PH_P_B, PH_P_C
	} phase_t;

	typedef enum logic {
		CFG_PHASE_DELAY   = 1'b0,
		CFG_RECOVER_DELAY = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		kind_t      kind;
		logic [6:0] dev;
		logic [7:0] regaddr;
		logic [7:0] value;
		logic [7:0] count;
		logic       sda;
		logic       scl;
	} entry_t;

	typedef struct packed {
		logic valid;
		logic pop;
	} qctl_t;
endpackage

// ===== src/i2cm_front.sv =====
// Front end: classifies incoming ticks and queues them for the bus engine.
module i2cm_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       opcode,
	input  logic [6:0]       device_address,
	input  logic [7:0]       register_address,
	input  logic [7:0]       write_value,
	input  logic [7:0]       read_count,
	input  logic             sda_level,
	input  logic             scl_level,
	input  logic             q_pop,
	output logic             q_valid,
	output i2cm_pkg::entry_t q_entry
);
	import i2cm_pkg::*;

	entry_t     mem_q [QDepth];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	entry_t     cls;
	logic       push;

	always_comb begin
		cls.dev     = device_address;
		cls.regaddr = register_address;
		cls.value   = write_value;
		cls.count   = read_count;
		cls.sda     = sda_level;
		cls.scl     = scl_level;
		case (opcode)
			OP_WRITE: cls.kind = K_WRITE;
			OP_READ:  cls.kind = (read_count == 8'd0) ? K_PARAM : K_READ;
			default:  cls.kind = K_TICK;
		endcase
	end

	assign in_ready = (count_q != 2'(QDepth));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

// ===== src/i2cm_back.sv =====
// Bus engine: runs the I2C phase sequencer one tick per beat and registers results.
`include "i2c_master_register_transactions_assert.svh"
module i2cm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [15:0]      cfg_data,
	input  logic             q_valid,
	input  i2cm_pkg::entry_t q_entry,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             scl_release,
	output logic             sda_release,
	output logic             read_valid,
	output logic [7:0]       read_byte,
	output logic             read_last,
	output logic             done_res,
	output logic [2:0]       status,
	output logic             busy_res
);
	import i2cm_pkg::*;

	logic [15:0] pdly_q, rdly_q;
	phase_t      phase_q, n_phase;
	logic [3:0]  bit_q, n_bit;
	logic [7:0]  shift_q, n_shift;
	logic [7:0]  left_q, n_left;
	logic [15:0] hold_q, n_hold;
	logic [3:0]  pulse_q, n_pulse;
	logic        rd_op_q, n_rd_op;
	logic [6:0]  dev_q, n_dev;
	logic [7:0]  reg_q, n_reg;
	logic [7:0]  val_q, n_val;
	logic [1:0]  ld_q, n_ld;
	stage_t      stage_q, n_stage;
	status_t     exit_q, n_exit;
	logic        o_rv, o_rl, o_done;
	logic [7:0]  o_rb;
	status_t     o_st;
	logic [7:0]  sh_w;
	logic [3:0]  bc_w;
	logic [3:0]  pc_w;
	logic [7:0]  bl_w;
	logic        sda, scl;

	assign q_pop = q_valid && (!out_valid || out_ready);
	assign sda   = q_entry.sda;
	assign scl   = q_entry.scl;

	always_comb begin
		n_phase = phase_q;  n_bit = bit_q;    n_shift = shift_q; n_left = left_q;
		n_hold  = hold_q;   n_pulse = pulse_q; n_rd_op = rd_op_q; n_dev = dev_q;
		n_reg   = reg_q;    n_val = val_q;    n_ld = ld_q;       n_stage = stage_q;
		n_exit  = exit_q;
		o_rv = 1'b0; o_rb = 8'd0; o_rl = 1'b0; o_done = 1'b0; o_st = ST_OK;
		sh_w = {shift_q[6:0], 1'b0};
		bc_w = bit_q + 4'd1;
		pc_w = pulse_q + 4'd1;
		bl_w = (left_q != 8'd0) ? left_q - 8'd1 : left_q;
		if (phase_q == PH_IDLE) begin
			case (q_entry.kind)
				K_PARAM: begin
					o_done = 1'b1; o_st = ST_PARAM;
				end
				K_WRITE, K_READ: begin
					n_rd_op = (q_entry.kind == K_READ);
					n_dev = q_entry.dev; n_reg = q_entry.regaddr; n_val = q_entry.value;
					n_left = (q_entry.kind == K_READ) ? q_entry.count : 8'd0;
					n_stage = STG_DEVW; n_exit = ST_OK; n_pulse = 4'd0;
					n_ld = 2'b11;
					if (!sda || !scl) begin
						n_phase = PH_R_REL; n_hold = rdly_q;
					end else begin
						n_phase = PH_S_A; n_hold = pdly_q;
					end
				end
				default: ;
			endcase
		end else if (hold_q != 16'd0) begin
			n_hold = hold_q - 16'd1;
		end else begin
			n_hold = pdly_q;
			case (phase_q)
				PH_R_REL: begin
					n_pulse = 4'd0; n_phase = PH_R_LOW; n_ld = 2'b01; n_hold = rdly_q;
				end
				PH_R_LOW: begin
					n_phase = PH_R_HIGH; n_ld = 2'b11; n_hold = rdly_q;
				end
				PH_R_HIGH: begin
					n_pulse = pc_w; n_hold = rdly_q;
					if (sda || ({4'd0, pc_w} >= RecoverPulses)) begin
						n_phase = PH_R_STA; n_ld = 2'b10;
					end else begin
						n_phase = PH_R_LOW; n_ld = 2'b01;
					end
				end
				PH_R_STA: begin
					n_phase = PH_R_STB; n_ld = 2'b10; n_hold = rdly_q;
				end
				PH_R_STB: begin
					n_phase = PH_R_STC; n_ld = 2'b11; n_hold = rdly_q;
				end
				PH_R_STC: begin
					if (sda && scl) begin
						n_phase = PH_S_A; n_ld = 2'b11;
					end else begin
						o_done = 1'b1; o_st = ST_BUSY;
						n_phase = PH_IDLE; n_ld = 2'b11; n_hold = 16'd0;
					end
				end
				PH_S_A: begin
					n_phase = PH_S_B; n_ld = 2'b10;
				end
				PH_S_B: begin
					n_phase = PH_S_C; n_ld = 2'b00;
				end
				PH_S_C: begin
					n_shift = {dev_q, stage_q == STG_DEVR};
					n_bit = 4'd0; n_phase = PH_W_DATA; n_ld = {1'b0, dev_q[6]};
				end
				PH_W_DATA: begin
					n_phase = PH_W_HIGH; n_ld = {1'b1, ld_q[0]};
				end
				PH_W_HIGH: begin
					n_phase = PH_W_LOW; n_ld = {1'b0, ld_q[0]};
				end
				PH_W_LOW: begin
					n_shift = sh_w; n_bit = bc_w;
					if (bc_w < 4'd8) begin
						n_phase = PH_W_DATA; n_ld = {1'b0, sh_w[7]};
					end else begin
						n_phase = PH_W_AREL; n_ld = 2'b01;
					end
				end
				PH_W_AREL: begin
					n_phase = PH_W_AHIGH; n_ld = 2'b11;
				end
				PH_W_AHIGH: begin
					n_exit = sda ? status_t'(3'd3 + stage_q) : ST_OK;
					n_phase = PH_W_ALOW; n_ld = 2'b01;
				end
				PH_W_ALOW: begin
					if (exit_q != ST_OK) begin
						n_phase = PH_P_A; n_ld = 2'b00;
					end else if (stage_q == STG_DEVW) begin
						n_stage = STG_REG; n_shift = reg_q; n_bit = 4'd0;
						n_phase = PH_W_DATA; n_ld = {1'b0, reg_q[7]};
					end else if (stage_q == STG_REG) begin
						if (rd_op_q) begin
							n_stage = STG_DEVR; n_phase = PH_S_A; n_ld = 2'b11;
						end else begin
							n_stage = STG_VAL; n_shift = val_q; n_bit = 4'd0;
							n_phase = PH_W_DATA; n_ld = {1'b0, val_q[7]};
						end
					end else if (stage_q == STG_DEVR) begin
						n_stage = STG_READ; n_shift = 8'd0; n_bit = 4'd0;
						n_phase = PH_D_HIGH; n_ld = 2'b11;
					end else begin
						n_phase = PH_P_A; n_ld = 2'b00;
					end
				end
				PH_D_HIGH: begin
					n_shift = {shift_q[6:0], sda}; n_bit = bc_w;
					if (bc_w >= 4'd8) begin
						o_rv = 1'b1; o_rb = {shift_q[6:0], sda};
						o_rl = (left_q <= 8'd1);
					end
					n_phase = PH_D_LOW; n_ld = 2'b01;
				end
				PH_D_LOW: begin
					if (bit_q < 4'd8) begin
						n_phase = PH_D_HIGH; n_ld = 2'b11;
					end else begin
						n_phase = PH_D_ASET; n_ld = {1'b0, left_q <= 8'd1};
					end
				end
				PH_D_ASET: begin
					n_phase = PH_D_AHIGH; n_ld = {1'b1, ld_q[0]};
				end
				PH_D_AHIGH: begin
					n_phase = PH_D_ALOW; n_ld = {1'b0, ld_q[0]};
				end
				PH_D_ALOW: begin
					n_left = bl_w;
					if (bl_w != 8'd0) begin
						n_shift = 8'd0; n_bit = 4'd0; n_phase = PH_D_HIGH; n_ld = 2'b11;
					end else begin
						n_phase = PH_P_A; n_ld = 2'b00;
					end
				end
				PH_P_A: begin
					n_phase = PH_P_B; n_ld = 2'b10;
				end
				PH_P_B: begin
					n_phase = PH_P_C; n_ld = 2'b11;
				end
				PH_P_C: begin
					o_done = 1'b1; o_st = exit_q;
					n_phase = PH_IDLE; n_ld = 2'b11; n_hold = 16'd0;
				end
				default: begin
					n_phase = PH_IDLE; n_ld = 2'b11; n_hold = 16'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pdly_q <= 16'd4; rdly_q <= 16'd5;
			phase_q <= PH_IDLE; bit_q <= 4'd0; shift_q <= 8'd0; left_q <= 8'd0;
			hold_q <= 16'd0; pulse_q <= 4'd0; rd_op_q <= 1'b0; dev_q <= 7'd0;
			reg_q <= 8'd0; val_q <= 8'd0; ld_q <= 2'b11; stage_q <= STG_DEVW;
			exit_q <= ST_OK; out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_PHASE_DELAY:   pdly_q <= cfg_data;
					CFG_RECOVER_DELAY: rdly_q <= cfg_data;
					default: ;
				endcase
			end
			if (q_pop) begin
				phase_q <= n_phase; bit_q <= n_bit; shift_q <= n_shift;
				left_q <= n_left; hold_q <= n_hold; pulse_q <= n_pulse;
				rd_op_q <= n_rd_op; dev_q <= n_dev; reg_q <= n_reg; val_q <= n_val;
				ld_q <= n_ld; stage_q <= n_stage; exit_q <= n_exit;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			scl_release <= ld_q[1];
			sda_release <= ld_q[0];
			read_valid  <= o_rv;
			read_byte   <= o_rb;
			read_last   <= o_rl;
			done_res    <= o_done;
			status      <= o_st;
			busy_res    <= (n_phase != PH_IDLE);
		end
	end

	`I2CM_ASSERT_IMPLIES(a_done_idle, clk, arst_n, out_valid && done_res, !busy_res)
	`I2CM_ASSERT_IMPLIES(a_read_busy, clk, arst_n, out_valid && read_valid, busy_res)
	`I2CM_ASSERT_IMPLIES(a_status_done, clk, arst_n, out_valid && status != ST_OK, done_res)
	`I2CM_ASSERT_HOLDS(a_idle_nohold, clk, arst_n, phase_q != PH_IDLE || hold_q == 16'd0)
endmodule

// ===== src/i2c_master_register_transactions.sv =====
// Top level of the I2C master register transaction block.
// Each input beat is one bus tick: sampled SDA and SCL plus an optional request
// (write one register, or burst-read read_count registers). Each input beat
// yields exactly one output beat with the line drive levels, a received byte
// with its last marker, a done flag with status, and the busy flag.
// A beat may be accepted every cycle; the sustained rate is one beat per cycle
// while the receiver does not stall. An accepted beat passes through the
// two-entry queue behind the classifier, then the engine's output register.
// The phase sequencer advances once per output beat.
// When the receiver stalls, the output register holds its beat, the engine
// freezes, and the queue fills; in_ready drops once both entries are taken.
// Reset clears the queue and sequencer, sets the drive state to released, and
// loads the phase and recovery delay defaults. The user must write the delay
// registers (cfg_we, cfg_index, cfg_data) only while idle; it is not enforced.
module i2c_master_register_transactions (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [6:0]  device_address,
	input  logic [7:0]  register_address,
	input  logic [7:0]  write_value,
	input  logic [7:0]  read_count,
	input  logic        sda_level,
	input  logic        scl_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        scl_release,
	output logic        sda_release,
	output logic        read_valid,
	output logic [7:0]  read_byte,
	output logic        read_last,
	output logic        done_res,
	output logic [2:0]  status,
	output logic        busy_res
);
	import i2cm_pkg::*;

	qctl_t  qctl;
	entry_t q_entry;

	i2cm_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .opcode, .device_address,
		.register_address, .write_value, .read_count, .sda_level, .scl_level,
		.q_pop(qctl.pop), .q_valid(qctl.valid), .q_entry
	);

	i2cm_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.q_valid(qctl.valid), .q_entry, .q_pop(qctl.pop),
		.out_valid, .out_ready, .scl_release, .sda_release, .read_valid,
		.read_byte, .read_last, .done_res, .status, .busy_res
	);
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the I2C master register transaction block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import i2cm_pkg::*;

	typedef struct packed {
		logic [1:0] op;
		logic [6:0] dev;
		logic [7:0] ra;
		logic [7:0] wv;
		logic [7:0] cnt;
		logic       sda;
		logic       scl;
	} tick_t;

	typedef struct packed {
		logic       scl_rel;
		logic       sda_rel;
		logic       rv;
		logic [7:0] rb;
		logic       rl;
		logic       done;
		logic [2:0] st;
		logic       busy;
	} bus_out_t;

	typedef struct {
		phase_t      ph;
		logic [3:0]  bits;
		logic [7:0]  shift;
		logic [7:0]  left;
		logic [15:0] hold;
		logic [3:0]  pulses;
		logic [1:0]  op;
		logic [6:0]  dev;
		logic [7:0]  ra;
		logic [7:0]  wv;
		logic [1:0]  drive;
		stage_t      stage;
		status_t     exit_st;
		logic [15:0] pdly;
		logic [15:0] rdly;
	} master_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic        out_ready = 1'b0;
	tick_t       beat_q = '0;
	bus_out_t    got;

	master_t  gen_m, chk_m;
	tick_t    pending_ticks[$];
	bus_out_t expected_out[$];
	int       send_idle = 0;
	int       recv_stall = 0;
	int       errors = 0;
	int       beats_seen = 0;
	int       hold_left = 0;
	bit       held_once = 0;

	i2c_master_register_transactions dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(beat_q.op), .device_address(beat_q.dev),
		.register_address(beat_q.ra), .write_value(beat_q.wv),
		.read_count(beat_q.cnt), .sda_level(beat_q.sda), .scl_level(beat_q.scl),
		.out_valid(out_valid), .out_ready(out_ready),
		.scl_release(got.scl_rel), .sda_release(got.sda_rel),
		.read_valid(got.rv), .read_byte(got.rb), .read_last(got.rl),
		.done_res(got.done), .status(got.st), .busy_res(got.busy)
	);

	always #5 clk = ~clk;

	function automatic void go(inout master_t s, input phase_t p, input logic c,
			input logic d, input logic [15:0] h);
		s.ph = p;
		s.drive = {c, d};
		s.hold = h;
	endfunction

	function automatic void send_byte(inout master_t s, input logic [7:0] v);
		s.shift = v;
		s.bits = 4'd0;
		go(s, PH_W_DATA, 1'b0, v[7], s.pdly);
	endfunction

	function automatic void advance(inout master_t s, input tick_t b, inout bus_out_t r);
		logic [15:0] d;
		logic [15:0] rd;
		d = s.pdly;
		rd = s.rdly;
		case (s.ph)
			PH_R_REL: begin
				s.pulses = 4'd0;
				go(s, PH_R_LOW, 1'b0, 1'b1, rd);
			end
			PH_R_LOW: go(s, PH_R_HIGH, 1'b1, 1'b1, rd);
			PH_R_HIGH: begin
				s.pulses = s.pulses + 4'd1;
				if (b.sda || s.pulses >= RecoverPulses[3:0])
					go(s, PH_R_STA, 1'b1, 1'b0, rd);
				else
					go(s, PH_R_LOW, 1'b0, 1'b1, rd);
			end
			PH_R_STA: go(s, PH_R_STB, 1'b1, 1'b0, rd);
			PH_R_STB: go(s, PH_R_STC, 1'b1, 1'b1, rd);
			PH_R_STC: begin
				if (b.sda && b.scl) begin
					go(s, PH_S_A, 1'b1, 1'b1, d);
				end else begin
					r.done = 1'b1;
					r.st = ST_BUSY;
					go(s, PH_IDLE, 1'b1, 1'b1, 16'd0);
				end
			end
			PH_S_A: go(s, PH_S_B, 1'b1, 1'b0, d);
			PH_S_B: go(s, PH_S_C, 1'b0, 1'b0, d);
			PH_S_C: send_byte(s, {s.dev, s.stage == STG_DEVR});
			PH_W_DATA: go(s, PH_W_HIGH, 1'b1, s.drive[0], d);
			PH_W_HIGH: go(s, PH_W_LOW, 1'b0, s.drive[0], d);
			PH_W_LOW: begin
				s.shift = s.shift << 1;
				s.bits = s.bits + 4'd1;
				if (s.bits < 4'd8)
					go(s, PH_W_DATA, 1'b0, s.shift[7], d);
				else
					go(s, PH_W_AREL, 1'b0, 1'b1, d);
			end
			PH_W_AREL: go(s, PH_W_AHIGH, 1'b1, 1'b1, d);
			PH_W_AHIGH: begin
				s.exit_st = b.sda ? status_t'(3'(3 + s.stage)) : ST_OK;
				go(s, PH_W_ALOW, 1'b0, 1'b1, d);
			end
			PH_W_ALOW: begin
				if (s.exit_st != ST_OK) begin
					go(s, PH_P_A, 1'b0, 1'b0, d);
				end else if (s.stage == STG_DEVW) begin
					s.stage = STG_REG;
					send_byte(s, s.ra);
				end else if (s.stage == STG_REG) begin
					if (s.op == OP_READ) begin
						s.stage = STG_DEVR;
						go(s, PH_S_A, 1'b1, 1'b1, d);
					end else begin
						s.stage = STG_VAL;
						send_byte(s, s.wv);
					end
				end else if (s.stage == STG_DEVR) begin
					s.stage = STG_READ;
					s.shift = 8'd0;
					s.bits = 4'd0;
					go(s, PH_D_HIGH, 1'b1, 1'b1, d);
				end else begin
					go(s, PH_P_A, 1'b0, 1'b0, d);
				end
			end
			PH_D_HIGH: begin
				s.shift = {s.shift[6:0], b.sda};
				s.bits = s.bits + 4'd1;
				if (s.bits >= 4'd8) begin
					r.rv = 1'b1;
					r.rb = s.shift;
					r.rl = s.left <= 8'd1;
				end
				go(s, PH_D_LOW, 1'b0, 1'b1, d);
			end
			PH_D_LOW: begin
				if (s.bits < 4'd8)
					go(s, PH_D_HIGH, 1'b1, 1'b1, d);
				else
					go(s, PH_D_ASET, 1'b0, s.left <= 8'd1, d);
			end
			PH_D_ASET: go(s, PH_D_AHIGH, 1'b1, s.drive[0], d);
			PH_D_AHIGH: go(s, PH_D_ALOW, 1'b0, s.drive[0], d);
			PH_D_ALOW: begin
				if (s.left > 8'd0)
					s.left = s.left - 8'd1;
				if (s.left > 8'd0) begin
					s.shift = 8'd0;
					s.bits = 4'd0;
					go(s, PH_D_HIGH, 1'b1, 1'b1, d);
				end else begin
					go(s, PH_P_A, 1'b0, 1'b0, d);
				end
			end
			PH_P_A: go(s, PH_P_B, 1'b1, 1'b0, d);
			PH_P_B: go(s, PH_P_C, 1'b1, 1'b1, d);
			PH_P_C: begin
				r.done = 1'b1;
				r.st = s.exit_st;
				go(s, PH_IDLE, 1'b1, 1'b1, 16'd0);
			end
			default: go(s, PH_IDLE, 1'b1, 1'b1, 16'd0);
		endcase
	endfunction

	function automatic void bus_tick(inout master_t s, input tick_t b, output bus_out_t r);
		r = '0;
		r.scl_rel = s.drive[1];
		r.sda_rel = s.drive[0];
		if (s.ph == PH_IDLE) begin
			if (b.op == OP_WRITE || b.op == OP_READ) begin
				if (b.op == OP_READ && b.cnt == 8'd0) begin
					r.done = 1'b1;
					r.st = ST_PARAM;
				end else begin
					s.op = b.op;
					s.dev = b.dev;
					s.ra = b.ra;
					s.wv = b.wv;
					s.left = (b.op == OP_READ) ? b.cnt : 8'd0;
					s.stage = STG_DEVW;
					s.exit_st = ST_OK;
					s.pulses = 4'd0;
					if (!b.sda || !b.scl)
						go(s, PH_R_REL, 1'b1, 1'b1, s.rdly);
					else
						go(s, PH_S_A, 1'b1, 1'b1, s.pdly);
				end
			end
		end else if (s.hold != 16'd0) begin
			s.hold = s.hold - 16'd1;
		end else begin
			advance(s, b, r);
		end
		r.busy = s.ph != PH_IDLE;
	endfunction

	function automatic void clear_master(output master_t s);
		s.ph = PH_IDLE;
		s.bits = 4'd0;
		s.shift = 8'd0;
		s.left = 8'd0;
		s.hold = 16'd0;
		s.pulses = 4'd0;
		s.op = 2'd0;
		s.dev = 7'd0;
		s.ra = 8'd0;
		s.wv = 8'd0;
		s.drive = 2'b11;
		s.stage = STG_DEVW;
		s.exit_st = ST_OK;
		s.pdly = 16'd4;
		s.rdly = 16'd5;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_t    nb;
		bus_out_t want;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				bus_tick(chk_m, beat_q, want);
				expected_out.push_back(want);
			end
			if (!in_valid || in_ready) begin
				if (pending_ticks.size() > 0 && $urandom_range(99) >= send_idle) begin
					nb = pending_ticks.pop_front();
					beat_q <= nb;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (beats_seen >= 20 && !held_once) begin
			held_once <= 1'b1;
			hold_left <= 300;
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(99) >= recv_stall;
		end
	end

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] act);
		if (want !== act) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, act);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		bus_out_t want;
		if (arst_n && out_valid && out_ready) begin
			beats_seen <= beats_seen + 1;
			if (expected_out.size() == 0) begin
				$display("%0t: unexpected beat %p", $time, got);
				errors++;
			end else begin
				want = expected_out.pop_front();
				check_field("scl_release", 8'(want.scl_rel), 8'(got.scl_rel));
				check_field("sda_release", 8'(want.sda_rel), 8'(got.sda_rel));
				check_field("read_valid", 8'(want.rv), 8'(got.rv));
				check_field("read_byte", want.rb, got.rb);
				check_field("read_last", 8'(want.rl), 8'(got.rl));
				check_field("done_res", 8'(want.done), 8'(got.done));
				check_field("status", 8'(want.st), 8'(got.st));
				check_field("busy_res", 8'(want.busy), 8'(got.busy));
			end
		end
	end

	task automatic emit(tick_t b);
		bus_out_t r;
		bus_tick(gen_m, b, r);
		pending_ticks.push_back(b);
	endtask

	task automatic run_request(logic [1:0] op, logic [6:0] dev, logic [7:0] ra,
			logic [7:0] wv, logic [7:0] cnt, logic sda0, logic scl0, bit stuck,
			int nack_pct);
		tick_t b;
		int    n;
		b = '{op: op, dev: dev, ra: ra, wv: wv, cnt: cnt, sda: sda0, scl: scl0};
		emit(b);
		while (gen_m.ph != PH_IDLE) begin
			b.op = ($urandom_range(7) == 0) ? 2'($urandom_range(1, 3)) : OP_TICK;
			b.dev = 7'($urandom);
			b.ra = 8'($urandom);
			b.wv = 8'($urandom);
			b.cnt = 8'($urandom);
			b.sda = 1'($urandom);
			b.scl = 1'($urandom);
			if (stuck) begin
				b.sda = 1'b0;
				b.scl = 1'b1;
			end else if (gen_m.ph == PH_W_AHIGH) begin
				b.sda = $urandom_range(99) < nack_pct;
			end else if (gen_m.ph == PH_R_STC) begin
				b.sda = 1'b1;
				b.scl = $urandom_range(7) != 0;
			end
			emit(b);
		end
		n = $urandom_range(3);
		repeat (n) begin
			b = 35'({$urandom, $urandom});
			b.op = ($urandom_range(1)) ? OP_TICK : 2'd3;
			emit(b);
		end
	endtask

	task automatic random_request();
		logic [1:0] op;
		logic [7:0] cnt;
		int         k;
		bit         lowstart;
		k = $urandom_range(99);
		op = (k < 40) ? OP_WRITE : OP_READ;
		if (k < 4)
			cnt = 8'd0;
		else
			cnt = 8'($urandom_range(1, 4));
		lowstart = $urandom_range(99) < 20;
		run_request(op, 7'($urandom), 8'($urandom), 8'($urandom), cnt,
				lowstart ? logic'($urandom) : 1'b1,
				lowstart ? logic'($urandom) : 1'b1,
				$urandom_range(99) < 5, 10);
	endtask

	task automatic drain();
		while (pending_ticks.size() > 0 || in_valid || expected_out.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		if (idx == CFG_PHASE_DELAY) begin
			gen_m.pdly = v;
			chk_m.pdly = v;
		end else begin
			gen_m.rdly = v;
			chk_m.rdly = v;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(logic [15:0] pd, logic [15:0] rd, int si, int rs, int n);
		write_reg(CFG_PHASE_DELAY, pd);
		write_reg(CFG_RECOVER_DELAY, rd);
		send_idle = si;
		recv_stall = rs;
		repeat (n) random_request();
		drain();
	endtask

	initial begin
		clear_master(gen_m);
		clear_master(chk_m);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_request(OP_READ, 7'h55, 8'h12, 8'h00, 8'h00, 1'b1, 1'b1, 0, 0);
		run_request(OP_WRITE, 7'h11, 8'h22, 8'h33, 8'h00, 1'b1, 1'b1, 0, 100);
		drain();

		write_reg(CFG_PHASE_DELAY, 16'd0);
		write_reg(CFG_RECOVER_DELAY, 16'd0);
		run_request(OP_WRITE, 7'h01, 8'h02, 8'h03, 8'h00, 1'b1, 1'b0, 1, 0);
		run_request(2'd3, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1, 0, 0);
		drain();
		random_phase(16'd0, 16'd0, 0, 0, 2);
		random_phase(16'd0, 16'd2, 76, 0, 1);
		random_phase(16'd0, 16'd3, 0, 76, 1);
		random_phase(16'd0, 16'd0, 38, 38, 1);

		write_reg(CFG_PHASE_DELAY, 16'hffff);
		write_reg(CFG_RECOVER_DELAY, 16'd1);
		send_idle = 0;
		recv_stall = 0;
		run_request(OP_READ, 7'($urandom), 8'($urandom), 8'($urandom), 8'h00,
				1'b1, 1'b1, 0, 0);
		run_request(OP_WRITE, 7'($urandom), 8'($urandom), 8'($urandom), 8'h00,
				1'b0, 1'b1, 1, 0);
		drain();
		write_reg(CFG_PHASE_DELAY, 16'd0);
		write_reg(CFG_RECOVER_DELAY, 16'hffff);
		run_request(OP_READ, 7'($urandom), 8'($urandom), 8'($urandom), 8'h00,
				1'b0, 1'b0, 0, 0);
		drain();

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#40ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
